[sv/range_majority_query_top_defines.svh]
// Assertion macros shared by the range majority query RTL.
`ifndef RANGE_MAJORITY_QUERY_TOP_DEFINES_SVH
`define RANGE_MAJORITY_QUERY_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/rmq_pkg.sv]
// Types, codes and defaults for the range majority query block.
package rmq_pkg;

  localparam int unsigned DefDepth      = 1024;
  localparam int unsigned DefValueWidth = 16;

  // Fixed payload field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned ElemW  = 16;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned ThrW   = 11;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VOTE,
    S_COUNT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [ElemW-1:0] elem_value;
    logic [IdxW-1:0]  range_left;
    logic [IdxW-1:0]  range_right;
    logic [ThrW-1:0]  min_count;
  } rmq_in_t;

  typedef struct packed {
    logic             found;
    logic [ElemW-1:0] majority_value;
    logic             bad_query;
  } rmq_out_t;

endpackage

[sv/range_majority_query_top.sv]
// Range majority query block: value store, query sequencer and shared compare unit.
// Clear and append requests complete on acceptance; an append to a full store is dropped.
// A query over left..right runs in steps from acceptance to the result:
// the single read port of the value store scans the range once for the majority vote and
// once to count the candidate, one entry per cycle, through a registered read in each pass,
// and then the answer moves into the output register once that register is free.
// A query that breaks the contract (left > right, right at or past the stored length,
// or twice the threshold not above the range length) skips both scans and answers with
// bad_query set. The block takes no request while a query runs; a finished result
// waits in an output register, and clear or append requests are still taken meanwhile.
// The store needs no clearing pass: only entries below the stored length are read.
`include "range_majority_query_top_defines.svh"

module range_majority_query_top
  import rmq_pkg::*;
#(
  parameter int unsigned DEPTH       = DefDepth,
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rmq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rmq_out_t out_data_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LenW  = $clog2(DEPTH + 1);
  localparam int unsigned PtrW  = (AddrW > IdxW) ? AddrW : IdxW;
  localparam int unsigned CmpW  = (LenW > IdxW) ? LenW : IdxW;

  // Value store
  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   we;

  // Control state
  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [PtrW-1:0] idx_q, idx_d;
  logic            issue_done_q, issue_done_d;
  logic            dval_q, dval_d;
  logic            dlast_q, dlast_d;
  logic            out_valid_q, out_valid_d;

  // Query payload
  logic [IdxW-1:0]        lft_q, lft_d;
  logic [IdxW-1:0]        rgt_q, rgt_d;
  logic [ThrW-1:0]        thr_q, thr_d;
  logic [VALUE_WIDTH-1:0] cand_q, cand_d;
  logic [ThrW-1:0]        tally_q, tally_d;
  logic                   found_q, found_d;
  logic                   bad_q, bad_d;
  rmq_out_t               out_q, out_d;

  // Accept-time checks
  logic            accept;
  logic [ThrW-1:0] range_len;
  logic            bad_now;
  logic            eq;
  logic [ThrW-1:0] tally_inc;
  logic [PtrW-1:0] rgt_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign range_len = ThrW'(in_data_i.range_right) - ThrW'(in_data_i.range_left) + ThrW'(1);
  assign bad_now   = (in_data_i.range_left > in_data_i.range_right)
                  || (CmpW'(in_data_i.range_right) >= CmpW'(len_q))
                  || ({in_data_i.min_count, 1'b0} <= {1'b0, range_len});

  // Shared compare unit: fetched entry against the candidate
  assign eq        = (rdata_q == cand_q);
  assign tally_inc = tally_q + ThrW'(eq);
  assign rgt_ext   = PtrW'(rgt_q);

  // Write on append, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[len_q[AddrW-1:0]] <= VALUE_WIDTH'(in_data_i.elem_value);
    end
    rdata_q <= mem_q[idx_q[AddrW-1:0]];
  end

  // Sequencer: next state, datapath updates and handshake
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    dval_d       = 1'b0;
    dlast_d      = dlast_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    lft_d        = lft_q;
    rgt_d        = rgt_q;
    thr_d        = thr_q;
    cand_d       = cand_q;
    tally_d      = tally_q;
    found_d      = found_q;
    bad_d        = bad_q;
    out_d        = out_q;
    we           = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(in_data_i.opcode))
            OP_CLEAR: begin
              len_d = '0;
            end
            OP_APPEND: begin
              if (len_q < LenW'(DEPTH)) begin
                we    = 1'b1;
                len_d = len_q + LenW'(1);
              end
            end
            OP_QUERY: begin
              lft_d = in_data_i.range_left;
              rgt_d = in_data_i.range_right;
              thr_d = in_data_i.min_count;
              if (bad_now) begin
                bad_d   = 1'b1;
                found_d = 1'b0;
                state_d = S_DONE;
              end else begin
                bad_d        = 1'b0;
                found_d      = 1'b0;
                idx_d        = PtrW'(in_data_i.range_left);
                issue_done_d = 1'b0;
                tally_d      = '0;
                state_d      = S_VOTE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_VOTE, S_COUNT: begin
        // Advance the read pointer until the last index is issued
        dval_d  = !issue_done_q;
        dlast_d = (idx_q == rgt_ext);
        if (!issue_done_q) begin
          idx_d = idx_q + PtrW'(1);
          if (idx_q == rgt_ext) begin
            issue_done_d = 1'b1;
          end
        end

        if (dval_q) begin
          if (state_q == S_VOTE) begin
            // Majority vote step
            if (tally_q == '0) begin
              cand_d  = rdata_q;
              tally_d = ThrW'(1);
            end else if (eq) begin
              tally_d = tally_q + ThrW'(1);
            end else begin
              tally_d = tally_q - ThrW'(1);
            end
            if (dlast_q) begin
              idx_d        = PtrW'(lft_q);
              issue_done_d = 1'b0;
              tally_d      = '0;
              state_d      = S_COUNT;
            end
          end else begin
            // Count the candidate
            tally_d = tally_inc;
            if (dlast_q) begin
              found_d = (tally_inc >= thr_q);
              state_d = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.found          = found_q;
          out_d.majority_value = found_q ? ElemW'(cand_q) : '0;
          out_d.bad_query      = bad_q;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      issue_done_q <= 1'b1;
      dval_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      len_q        <= len_d;
      issue_done_q <= issue_done_d;
      dval_q       <= dval_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    dlast_q <= dlast_d;
    lft_q   <= lft_d;
    rgt_q   <= rgt_d;
    thr_q   <= thr_d;
    cand_q  <= cand_d;
    tally_q <= tally_d;
    found_q <= found_d;
    bad_q   <= bad_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `RMQ_ASSERT(a_len_bound, (len_q <= LenW'(DEPTH)), "stored length beyond depth")
  `RMQ_ASSERT(a_found_bad_excl, out_valid_o |-> !(out_data_o.found && out_data_o.bad_query), "found and bad_query both set")
  `RMQ_ASSERT(a_value_zero, (out_valid_o && !out_data_o.found) |-> (out_data_o.majority_value == '0), "value not zero without a match")
  `RMQ_ASSERT(a_good_query_scans, (accept && (in_data_i.opcode == OP_QUERY) && !bad_now) |=> (state_q == S_VOTE), "valid query did not start the vote pass")
  `RMQ_ASSERT(a_result_from_done, $rose(out_valid_o) |-> ($past(state_q) == S_DONE), "result raised outside the done step")

endmodule

[test/range_majority_query_checker.sv]
// Checker for the range majority query block: shadow store, answer prediction and compare.
`timescale 1ns / 1ps

module range_majority_query_checker
  import rmq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  rmq_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  rmq_out_t out_data_i,
  output int       mismatches_o,
  output int       owed_o
);

  logic [DefValueWidth-1:0] shadow_store [DefDepth];
  int unsigned              shadow_len;
  rmq_out_t                 owed_answers [$];
  int                       mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Vote for a candidate over lo..hi, then count it against the threshold.
  function automatic rmq_out_t majority_answer(int unsigned lo, int unsigned hi,
                                               int unsigned need);
    rmq_out_t                 ans;
    logic [DefValueWidth-1:0] leader;
    int unsigned              lead;
    int unsigned              hits;
    int unsigned              span;
    ans    = '0;
    leader = '0;
    lead   = 0;
    hits   = 0;
    if (lo > hi || hi >= shadow_len) begin
      ans.bad_query = 1'b1;
    end else begin
      span = hi - lo + 1;
      if (2 * need <= span) begin
        ans.bad_query = 1'b1;
      end else begin
        for (int unsigned i = lo; i <= hi; i++) begin
          if (lead == 0) begin
            leader = shadow_store[i];
            lead   = 1;
          end else if (shadow_store[i] == leader) begin
            lead++;
          end else begin
            lead--;
          end
        end
        for (int unsigned i = lo; i <= hi; i++) begin
          if (shadow_store[i] == leader) hits++;
        end
        if (hits >= need) begin
          ans.found          = 1'b1;
          ans.majority_value = ElemW'(leader);
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rmq_out_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      owed_answers.delete();
      owed_o <= 0;
    end else begin
      // Compare each accepted answer with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (owed_answers.size() == 0) begin
          report_mismatch("answer with no query outstanding");
        end else begin
          want = owed_answers.pop_front();
          if (out_data_i.found !== want.found)
            report_mismatch($sformatf("found %b, predicted %b",
                                      out_data_i.found, want.found));
          if (out_data_i.majority_value !== want.majority_value)
            report_mismatch($sformatf("majority_value %h, predicted %h",
                                      out_data_i.majority_value, want.majority_value));
          if (out_data_i.bad_query !== want.bad_query)
            report_mismatch($sformatf("bad_query %b, predicted %b",
                                      out_data_i.bad_query, want.bad_query));
        end
      end
      // Advance the shadow store on each accepted request.
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.opcode)
          OP_CLEAR: begin
            shadow_len = 0;
          end
          OP_APPEND: begin
            if (shadow_len < DefDepth) begin
              shadow_store[shadow_len] = DefValueWidth'(in_data_i.elem_value);
              shadow_len++;
            end
          end
          OP_QUERY: begin
            owed_answers = {owed_answers, majority_answer(in_data_i.range_left,
                                                          in_data_i.range_right,
                                                          in_data_i.min_count)};
          end
          default: begin
            // Drop the unused opcode.
          end
        endcase
      end
      owed_o <= owed_answers.size();
    end
  end

endmodule

[test/tb.sv]
// Testbench top for the range majority query block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import rmq_pkg::*;

  localparam logic [OpW-1:0] OpReserved = 2'd3;
  localparam int             TotalItems = 290;
  localparam int             FillItems  = 60;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rmq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rmq_out_t out_data;
  int       mismatches;
  int       owed;

  int          burst_left = 1;
  int          sent_items = 0;
  int unsigned stim_len   = 0;
  int unsigned sink_mode  = 0;
  int unsigned sink_left  = 0;

  always #5 clk = ~clk;

  range_majority_query_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  range_majority_query_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .owed_o      (owed)
  );

  // Stall the answer channel; switch between full rate and sparse acceptance.
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_left <= $urandom_range(16, 300);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  function automatic rmq_in_t scrambled_request(input logic [OpW-1:0] op);
    rmq_in_t r;
    r.opcode      = op;
    r.elem_value  = ElemW'($urandom);
    r.range_left  = IdxW'($urandom);
    r.range_right = IdxW'($urandom);
    r.min_count   = ThrW'($urandom);
    return r;
  endfunction

  // Hold the request until accepted, then maybe end the burst with a gap.
  task automatic push_request(input rmq_in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (req.opcode != OpReserved) sent_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic clear_store();
    push_request(scrambled_request(OP_CLEAR));
    stim_len = 0;
  endtask

  task automatic append_value(input logic [ElemW-1:0] v);
    rmq_in_t r;
    r = scrambled_request(OP_APPEND);
    r.elem_value = v;
    push_request(r);
    if (stim_len < DefDepth) stim_len++;
  endtask

  task automatic ask(input int unsigned lo, input int unsigned hi, input int unsigned need);
    rmq_in_t r;
    r = scrambled_request(OP_QUERY);
    r.range_left  = IdxW'(lo);
    r.range_right = IdxW'(hi);
    r.min_count   = ThrW'(need);
    push_request(r);
  endtask

  // Hold off until every predicted answer has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  // Query a random valid range of the current store, threshold mostly near half.
  task automatic ask_in_store();
    int unsigned lo, hi, span, need;
    lo   = $urandom_range(0, stim_len - 1);
    hi   = $urandom_range(lo, stim_len - 1);
    span = hi - lo + 1;
    case ($urandom_range(0, 5))
      0, 1, 2: need = span / 2 + 1;
      3:       need = $urandom_range(span / 2 + 1, span + 2);
      4:       need = span / 2;
      default: need = $urandom_range(1, span);
    endcase
    ask(lo, hi, need);
  endtask

  initial begin
    int unsigned n, dom, alt, pick, random_start;
    bit          paused;
    paused = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, unused opcode, edges of the query contract.
    ask(0, 0, 1);
    push_request(scrambled_request(OpReserved));
    append_value(16'h0000);
    append_value(16'hFFFF);
    append_value(16'hFFFF);
    append_value(16'h1234);
    ask(1, 2, 2);
    ask(0, 3, 3);
    ask(1, 2, 3);
    ask(0, 3, 2);
    ask(0, 3, 0);
    ask(2, 1, 2);
    ask(0, 4, 3);
    ask(3, 3, 1);
    ask(0, 0, 2047);
    clear_store();
    ask(0, 0, 1);
    append_value(16'h0007);
    ask(0, 0, 1);
    drain();

    // Fill a longer store, then query its widest range and some narrower ones.
    clear_store();
    for (int i = 0; i < FillItems; i++)
      append_value((i % 5 < 3) ? 16'hA5C3 : ElemW'($urandom));
    ask(0, FillItems - 1, FillItems / 2 + 1);
    ask(0, FillItems - 1, FillItems);
    ask(0, FillItems - 1, FillItems / 2);
    ask(FillItems - 1, FillItems - 1, 1);
    ask(FillItems / 2, FillItems - 1, FillItems / 4 + 1);
    repeat (3) ask_in_store();
    clear_store();

    // Random: mostly stores with a dominant value, some noise.
    random_start = sent_items;
    while (sent_items < TotalItems) begin
      if (!paused && sent_items > random_start + (TotalItems - random_start) / 2) begin
        paused = 1;
        drain();
      end
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) != 0) clear_store();
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        dom  = $urandom;
        alt  = $urandom;
        for (int unsigned i = 0; i < n && stim_len < DefDepth && sent_items < TotalItems;
             i++) begin
          pick = $urandom_range(0, 9);
          append_value(pick < 6 ? ElemW'(dom) : (pick < 8 ? ElemW'(alt) : ElemW'($urandom)));
        end
        n = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n; i++) begin
          if (stim_len > 0) ask_in_store();
        end
      end else begin
        case ($urandom_range(0, 4))
          0: ask($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 2047));
          1: push_request(scrambled_request(OpReserved));
          2: append_value(ElemW'($urandom));
          3: clear_store();
          default: begin
            if (stim_len > 1 && $urandom_range(0, 1) == 0)
              ask(stim_len - 1, $urandom_range(0, stim_len - 2), 1);
            else
              ask(0, stim_len, 1);
          end
        endcase
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Bound the run well beyond the slowest correct completion.
  initial begin
    #(20_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
